// File: hdl/sfwd_pkg.sv
// ----------------------------------------------------------------------------
// sfwd_pkg
// Shared constants and types for the sync frame word deframer.
// ----------------------------------------------------------------------------
package sfwd_pkg;

   localparam int WORDS_PER_FRAME_DEF = 15;
   localparam int WORD_INDEX_W        = 4;
   localparam int BYTE_W              = 8;
   localparam int WORD_W              = 16;

   localparam logic [BYTE_W-1:0] CHAR_S = 8'h53;
   localparam logic [BYTE_W-1:0] CHAR_J = 8'h4A;
   localparam logic [BYTE_W-1:0] CHAR_T = 8'h54;
   localparam logic [BYTE_W-1:0] CHAR_U = 8'h55;

   typedef struct packed {
      logic byte_shift;
      logic word_shift;
   } shift_ctl_type;

endpackage

// File: hdl/sfwd_cell.sv
// ----------------------------------------------------------------------------
// sfwd_cell
// One 16-bit payload cell. Byte shift moves lo into hi and takes the
// neighbor's hi byte; word shift takes the neighbor's whole word.
// ----------------------------------------------------------------------------
module sfwd_cell
   import sfwd_pkg::*;
(
   input  logic                clock,
   input  shift_ctl_type       ctl,
   input  logic [WORD_W-1:0]   din,
   output logic [WORD_W-1:0]   word
);

   logic [WORD_W-1:0] word_ff;
   logic [WORD_W-1:0] word_in;

   always_comb begin
      word_in = word_ff;
      if (ctl.word_shift) begin
         word_in = din;
      end else if (ctl.byte_shift) begin
         word_in = {word_ff[BYTE_W-1:0], din[WORD_W-1:BYTE_W]};
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;

endmodule

// File: hdl/sfwd_ctrl.sv
// ----------------------------------------------------------------------------
// sfwd_ctrl
// Frame parser and word drain sequencer; drives the cell row shifts.
// ----------------------------------------------------------------------------
module sfwd_ctrl
   import sfwd_pkg::*;
#(
   parameter int WORDS_PER_FRAME = WORDS_PER_FRAME_DEF
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [BYTE_W-1:0]        rx_byte,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [WORD_INDEX_W-1:0]  word_index,
   output logic                     last_word,
   output shift_ctl_type            ctl
);

   localparam int BCNT_W = (2*WORDS_PER_FRAME > 1) ? $clog2(2*WORDS_PER_FRAME) : 1;
   localparam int WCNT_W = (WORDS_PER_FRAME > 1) ? $clog2(WORDS_PER_FRAME) : 1;
   localparam logic [BCNT_W-1:0] BYTE_LAST = BCNT_W'(2*WORDS_PER_FRAME - 1);
   localparam logic [WCNT_W-1:0] WORD_LAST = WCNT_W'(WORDS_PER_FRAME - 1);

   typedef enum logic [5:0] {
      ST_HUNT_S  = 6'b000001,
      ST_WANT_J  = 6'b000010,
      ST_PAYLOAD = 6'b000100,
      ST_WANT_T  = 6'b001000,
      ST_WANT_U  = 6'b010000,
      ST_DRAIN   = 6'b100000
   } state_type;

   state_type          state_ff, state_in;
   logic [BCNT_W-1:0]  bcnt_ff, bcnt_in;
   logic [WCNT_W-1:0]  wcnt_ff, wcnt_in;
   logic [WCNT_W+WORD_INDEX_W-1:0] wcnt_ext;
   logic               req_xfer;
   logic               rsp_xfer;

   assign req_ready = (state_ff != ST_DRAIN);
   assign rsp_valid = (state_ff == ST_DRAIN);
   assign req_xfer  = req_valid & req_ready;
   assign rsp_xfer  = rsp_valid & rsp_ready;

   always_comb begin
      state_in       = state_ff;
      bcnt_in        = bcnt_ff;
      wcnt_in        = wcnt_ff;
      ctl.byte_shift = 1'b0;
      ctl.word_shift = 1'b0;
      unique case (state_ff)
         ST_HUNT_S: begin
            if (req_xfer) begin
               state_in = (rx_byte == CHAR_S) ? ST_WANT_J : ST_HUNT_S;
            end
         end
         ST_WANT_J: begin
            if (req_xfer) begin
               state_in = (rx_byte == CHAR_J) ? ST_PAYLOAD : ST_HUNT_S;
               bcnt_in  = '0;
            end
         end
         ST_PAYLOAD: begin
            if (req_xfer) begin
               ctl.byte_shift = 1'b1;
               if (bcnt_ff == BYTE_LAST) begin
                  state_in = ST_WANT_T;
               end else begin
                  bcnt_in = bcnt_ff + 1'b1;
               end
            end
         end
         ST_WANT_T: begin
            if (req_xfer) begin
               state_in = (rx_byte == CHAR_T) ? ST_WANT_U : ST_HUNT_S;
            end
         end
         ST_WANT_U: begin
            if (req_xfer) begin
               state_in = (rx_byte == CHAR_U) ? ST_DRAIN : ST_HUNT_S;
               wcnt_in  = '0;
            end
         end
         ST_DRAIN: begin
            if (rsp_xfer) begin
               ctl.word_shift = 1'b1;
               if (wcnt_ff == WORD_LAST) begin
                  state_in = ST_HUNT_S;
               end else begin
                  wcnt_in = wcnt_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_HUNT_S;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_HUNT_S;
         bcnt_ff  <= '0;
         wcnt_ff  <= '0;
      end else begin
         state_ff <= state_in;
         bcnt_ff  <= bcnt_in;
         wcnt_ff  <= wcnt_in;
      end
   end

   assign wcnt_ext   = {{WORD_INDEX_W{1'b0}}, wcnt_ff};
   assign word_index = wcnt_ext[WORD_INDEX_W-1:0];
   assign last_word  = (wcnt_ff == WORD_LAST);

   a_no_req_during_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input taken while words drain");

   a_shift_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(ctl.byte_shift && ctl.word_shift))
      else $error("byte and word shift together");

   a_drain_starts_at_zero: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> (wcnt_ff == '0))
      else $error("drain did not start at word zero");

   a_last_ends_drain: assert property (@(posedge clock) disable iff (reset)
      (rsp_xfer && last_word) |=> !rsp_valid && req_ready)
      else $error("drain continued past last word");

   a_payload_follows_header: assert property (@(posedge clock) disable iff (reset)
      ctl.byte_shift |-> $past(state_ff == ST_WANT_J || state_ff == ST_PAYLOAD))
      else $error("payload byte without header");

endmodule

// File: hdl/sync_frame_word_deframer.sv
// ----------------------------------------------------------------------------
// sync_frame_word_deframer
// Serial byte stream to 16-bit word deframer for 'S' 'J' ... 'T' 'U' frames.
// ----------------------------------------------------------------------------
// One received byte is taken per cycle while parsing, in header hunt, payload
// store and trailer check alike. Payload bytes shift into a row of
// WORDS_PER_FRAME word cells. Once 'U' closes a frame, the row drains one word
// per cycle from its head while rsp_ready is high, and no byte is taken during
// that burst. A header or trailer mismatch drops back to header hunt without
// rechecking the offending byte.
module sync_frame_word_deframer
   import sfwd_pkg::*;
#(
   parameter int WORDS_PER_FRAME = WORDS_PER_FRAME_DEF
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [BYTE_W-1:0]        req_rx_byte,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [WORD_W-1:0]        rsp_sensor_word,
   output logic [WORD_INDEX_W-1:0]  rsp_word_index,
   output logic                     rsp_last_word
);

   shift_ctl_type      ctl;
   logic [WORD_W-1:0]  chain [WORDS_PER_FRAME+1];

   sfwd_ctrl #(
      .WORDS_PER_FRAME (WORDS_PER_FRAME)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .rx_byte    (req_rx_byte),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .word_index (rsp_word_index),
      .last_word  (rsp_last_word),
      .ctl        (ctl)
   );

   assign chain[WORDS_PER_FRAME] = {req_rx_byte, {BYTE_W{1'b0}}};

   for (genvar i = 0; i < WORDS_PER_FRAME; i++) begin : g_cell
      sfwd_cell u_cell (
         .clock (clock),
         .ctl   (ctl),
         .din   (chain[i+1]),
         .word  (chain[i])
      );
   end

   assign rsp_sensor_word = chain[0];

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sync frame word deframer.
// ----------------------------------------------------------------------------
// Feeds byte streams through the request channel: a short directed opening,
// then mostly well-formed 'S' 'J' ... 'T' 'U' frames with random payloads,
// mixed with broken headers, broken trailers and noise. A software copy of
// the parser predicts the word burst of every closed frame. Each rsp transfer
// is checked in order against that prediction. Both channels stall at random.
// ----------------------------------------------------------------------------
module tb;
   import sfwd_pkg::*;

   localparam int WORDS      = WORDS_PER_FRAME_DEF;
   localparam int PAY_BYTES  = 2 * WORDS;
   localparam int POS_HUNT_S = 0;
   localparam int POS_WANT_J = 1;
   localparam int POS_PAY    = 2;
   localparam int POS_WANT_T = POS_PAY + PAY_BYTES;
   localparam int POS_WANT_U = POS_WANT_T + 1;
   localparam int NUM_ITEMS  = 310;

   typedef enum int {FLAW_NONE, FLAW_J, FLAW_T, FLAW_U} frame_flaw_type;

   typedef struct packed {
      logic [WORD_W-1:0]       word;
      logic [WORD_INDEX_W-1:0] idx;
      logic                    last;
   } sensor_word_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [BYTE_W-1:0]       req_rx_byte = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [WORD_W-1:0]       rsp_sensor_word;
   logic [WORD_INDEX_W-1:0] rsp_word_index;
   logic                    rsp_last_word;

   logic [BYTE_W-1:0] rx_byte_q[$];
   sensor_word_type   word_expect_q[$];
   int                err_count = 0;

   int                frame_pos = POS_HUNT_S;
   logic [BYTE_W-1:0] payload_mem [PAY_BYTES];

   int req_gap  = 0;
   bit req_calm = 1'b0;
   int rsp_hold = 0;
   bit rsp_calm = 1'b0;

   sync_frame_word_deframer DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_sensor_word (rsp_sensor_word),
      .rsp_word_index  (rsp_word_index),
      .rsp_last_word   (rsp_last_word)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic int pick_gap(input bit calm);
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [BYTE_W-1:0] pick_other(input logic [BYTE_W-1:0] avoid);
      logic [BYTE_W-1:0] b;
      do b = BYTE_W'($urandom_range(0, 255)); while (b == avoid);
      return b;
   endfunction

   function automatic logic [BYTE_W-1:0] pick_payload();
      case ($urandom_range(0, 9))
         0: return CHAR_S;
         1: return CHAR_T;
         2: return CHAR_U;
         3: return 8'h00;
         4: return 8'hFF;
         default: return BYTE_W'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic add_frame(input frame_flaw_type flaw);
      rx_byte_q.push_back(CHAR_S);
      if (flaw == FLAW_J) begin
         rx_byte_q.push_back(pick_other(CHAR_J));
         return;
      end
      rx_byte_q.push_back(CHAR_J);
      for (int i = 0; i < PAY_BYTES; i++) rx_byte_q.push_back(pick_payload());
      if (flaw == FLAW_T) begin
         rx_byte_q.push_back(pick_other(CHAR_T));
         return;
      end
      rx_byte_q.push_back(CHAR_T);
      rx_byte_q.push_back(flaw == FLAW_U ? pick_other(CHAR_U) : CHAR_U);
   endtask

   // software copy of the parser; queues the word burst of each closed frame
   task automatic parse_byte(input logic [BYTE_W-1:0] b);
      sensor_word_type w;
      if (frame_pos == POS_HUNT_S) begin
         frame_pos = (b == CHAR_S) ? POS_WANT_J : POS_HUNT_S;
      end else if (frame_pos == POS_WANT_J) begin
         frame_pos = (b == CHAR_J) ? POS_PAY : POS_HUNT_S;
      end else if (frame_pos < POS_WANT_T) begin
         payload_mem[frame_pos - POS_PAY] = b;
         frame_pos++;
      end else if (frame_pos == POS_WANT_T) begin
         frame_pos = (b == CHAR_T) ? POS_WANT_U : POS_HUNT_S;
      end else begin
         frame_pos = POS_HUNT_S;
         if (b == CHAR_U) begin
            for (int k = 0; k < WORDS; k++) begin
               w.word = {payload_mem[2*k], payload_mem[2*k+1]};
               w.idx  = k[WORD_INDEX_W-1:0];
               w.last = (k == WORDS - 1);
               word_expect_q.push_back(w);
            end
         end
      end
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (rx_byte_q.size() > 0) begin
            req_rx_byte <= rx_byte_q.pop_front();
            req_valid   <= 1'b1;
            if ($urandom_range(0, 49) == 0) req_calm = !req_calm;
            req_gap = pick_gap(req_calm);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response stall driver
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 49) == 0) rsp_calm = !rsp_calm;
         rsp_hold = pick_gap(rsp_calm);
      end
   end

   // monitor: predict on each req transfer, check each rsp transfer
   always @(posedge clock) begin
      sensor_word_type got;
      sensor_word_type exp_w;
      if (!reset) begin
         if (req_valid && req_ready) parse_byte(req_rx_byte);
         if (rsp_valid && rsp_ready) begin
            got = {rsp_sensor_word, rsp_word_index, rsp_last_word};
            if (word_expect_q.size() == 0) begin
               err_count++;
               $display("%0t: unexpected word %h idx %0d last %b", $time,
                        got.word, got.idx, got.last);
            end else begin
               exp_w = word_expect_q.pop_front();
               if (got !== exp_w) begin
                  err_count++;
                  $display("%0t: expected word %h idx %0d last %b, got %h idx %0d last %b",
                           $time, exp_w.word, exp_w.idx, exp_w.last,
                           got.word, got.idx, got.last);
               end
            end
         end
      end
   end

   initial begin
      int r;
      logic [BYTE_W-1:0] b;

      // stray bytes, 'S' followed by a non-'J', and 'S' 'S' 'J' which must not sync
      rx_byte_q = '{8'h00, CHAR_S, 8'hFF, CHAR_S, CHAR_S, CHAR_J, CHAR_U};
      rx_byte_q.push_back(CHAR_S);
      rx_byte_q.push_back(CHAR_J);
      for (int i = 0; i < PAY_BYTES; i++) begin
         case (i)
            0, 1:    b = 8'h00;
            2, 3:    b = 8'hFF;
            4:       b = CHAR_S;
            5:       b = CHAR_T;
            6:       b = CHAR_U;
            7:       b = CHAR_J;
            default: b = 8'(i * 37 + 11);
         endcase
         rx_byte_q.push_back(b);
      end
      rx_byte_q.push_back(CHAR_T);
      rx_byte_q.push_back(CHAR_U);

      while (rx_byte_q.size() < NUM_ITEMS) begin
         r = $urandom_range(0, 99);
         if (r < 65)      add_frame(FLAW_NONE);
         else if (r < 73) add_frame(FLAW_J);
         else if (r < 81) add_frame(FLAW_T);
         else if (r < 89) add_frame(FLAW_U);
         else begin
            repeat ($urandom_range(1, 6))
               rx_byte_q.push_back(BYTE_W'($urandom_range(0, 255)));
         end
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (rx_byte_q.size() != 0 || req_valid) @(posedge clock);
      while (word_expect_q.size() != 0) @(posedge clock);
      repeat (4 * WORDS + 20) @(posedge clock);

      if (err_count == 0) begin
         $display("sync_frame_word_deframer verification clean");
      end else begin
         $display("sync_frame_word_deframer verification failed");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("%0t: timeout", $time);
      $display("sync_frame_word_deframer verification failed");
      $finish;
   end

endmodule
